>>> src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> src/sha_ram.sv
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/sha_round.sv
// One SHA-256 round over the working variables.
module sha_round (
  input  logic [255:0] v_in,
  input  logic [31:0]  k,
  input  logic [31:0]  w,
  output logic [255:0] v_out
);
  import sha_pkg::*;

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_in;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    v_out = {t1 + t2, a, b, c, d + t1, e, f, g};
  end

endmodule

>>> src/sha256_byte_stream_hasher.sv
// A byte that does not fill a block is written to the block memory as it is accepted; a byte
//   that fills a block starts a compression: the block load, the rounds and a chaining step.
// Closing item: pad bytes one per cycle up to the block end, one or two compressions,
//   then eight digest words, one per accepted output word.
// Throughput is set by the byte-wide load and the one-round-per-cycle loop; no input byte
//   is taken while a block compresses. Reset (rst_n low, synchronous): IV, counts to zero.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic [0:0]  in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero pad
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  state_t       state_r, state_nxt;
  logic [5:0]   fill_r;
  logic [63:0]  bits_r, total_r;
  logic [255:0] chain_r, v_r, v_round;
  logic [6:0]   rnd_r;        // round / load step counter
  logic         closing_r;    // compressing a block inside the pad sequence
  logic         pad80_r;      // 0x80 marker already written
  logic         final_blk_r;  // length field goes into the current block
  logic [2:0]   widx_r;

  // block memory, 64 bytes
  logic       bwe;
  logic [5:0] bwa, bra;
  logic [7:0] bwd, brd;
  // schedule window memories: four read ports made from duplicate copies
  logic       swe;
  logic [3:0] swa, sra0, sra1, sra2, sra3;
  logic [31:0] swd, srd0, srd1, srd2, srd3;
  logic [31:0] w_cur, s0, s1, wsum;
  logic [31:0] ld_word_r;

  sha_ram #(.Width(8), .Depth(BlockBytes)) u_blk (
    .clk(clk), .wr_en(bwe), .wr_addr(bwa), .wr_data(bwd), .rd_addr(bra), .rd_data(brd));
  sha_ram #(.Width(32), .Depth(16)) u_w0 (
    .clk(clk), .wr_en(swe), .wr_addr(swa), .wr_data(swd), .rd_addr(sra0), .rd_data(srd0));
  sha_ram #(.Width(32), .Depth(16)) u_w1 (
    .clk(clk), .wr_en(swe), .wr_addr(swa), .wr_data(swd), .rd_addr(sra1), .rd_data(srd1));
  sha_ram #(.Width(32), .Depth(16)) u_w2 (
    .clk(clk), .wr_en(swe), .wr_addr(swa), .wr_data(swd), .rd_addr(sra2), .rd_data(srd2));
  sha_ram #(.Width(32), .Depth(16)) u_w3 (
    .clk(clk), .wr_en(swe), .wr_addr(swa), .wr_data(swd), .rd_addr(sra3), .rd_data(srd3));

  sha_round u_rnd (.v_in(v_r), .k(round_k(rnd_r[5:0])), .w(w_cur), .v_out(v_round));

  // ST_LOAD: rnd_r 0..64 reads bytes; byte i arrives at step i+1, word written at
  //   step 4j+4. Then ST_ROUND with rnd_r = round; window reads are addressed for the next round.
  logic [3:0] rr;
  assign rr = rnd_r[3:0];
  assign s1 = rotr(srd0, 17) ^ rotr(srd0, 19) ^ (srd0 >> 10);
  assign s0 = rotr(srd1, 7) ^ rotr(srd1, 18) ^ (srd1 >> 3);
  assign wsum = s1 + srd2 + s0 + srd3;
  assign w_cur = (rnd_r < 7'd16) ? srd3 : wsum;

  logic [7:0] pad_byte;
  always_comb begin
    // 0x80 first, then zeros; length bytes at 56..63 of the last block, big-endian
    if (!pad80_r) begin
      pad_byte = PadByte;
    end else if (final_blk_r && fill_r >= 6'(LenPos)) begin
      pad_byte = total_r[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    bwe = 1'b0; bwa = fill_r; bwd = in_tdata; bra = rnd_r[5:0];
    swe = 1'b0; swa = rr; swd = ld_word_r;
    sra0 = 4'(rnd_r + 7'd15); sra1 = 4'(rnd_r + 7'd2);
    sra2 = 4'(rnd_r + 7'd10); sra3 = 4'(rnd_r + 7'd1);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          bwe = in_tuser[0];
          if (in_tuser[0] && fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        bwe = 1'b1; bwd = pad_byte;
        if (fill_r == 6'd63) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        swe = (rnd_r[1:0] == 2'd0) && (rnd_r != 7'd0);
        swa = 4'(rnd_r[5:2] - 4'd1);
        swd = {ld_word_r[23:0], brd};
        sra3 = 4'd0;
        if (rnd_r == 7'd64) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        swe = 1'b1; swa = rr; swd = w_cur;
        if (rnd_r == 7'd63) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (closing_r && final_blk_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = closing_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_tready && widx_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The load reads byte rnd_r and the registered read returns it at step rnd_r+1; last write at step 64.
  // rnd_r runs 0..64 in load; sra3 at step 64 fetches window[0] for round 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      closing_r   <= 1'b0;
      pad80_r     <= 1'b0;
      final_blk_r <= 1'b0;
      widx_r      <= '0;
      for (int i = 0; i < 8; i++) chain_r[255 - 32 * i -: 32] <= init_hash(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          rnd_r       <= '0;
          pad80_r     <= 1'b0;
          final_blk_r <= 1'b0;
          if (in_tvalid) begin
            if (in_tuser[0]) begin
              fill_r <= fill_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
            closing_r <= in_tlast;
            total_r   <= in_tuser[0] ? bits_r + 64'd8 : bits_r;
          end
        end
        ST_PAD: begin
          fill_r <= fill_r + 6'd1;
          rnd_r  <= '0;
          if (!pad80_r) begin
            // marker below byte 56 leaves room for the length in this block
            pad80_r     <= 1'b1;
            final_blk_r <= (fill_r < 6'(LenPos));
          end
        end
        ST_LOAD: begin
          ld_word_r <= {ld_word_r[23:0], brd};
          rnd_r <= (rnd_r == 7'd64) ? 7'd0 : rnd_r + 7'd1;
          v_r   <= chain_r;
        end
        ST_ROUND: begin
          v_r   <= v_round;
          rnd_r <= (rnd_r == 7'd63) ? 7'd64 : rnd_r + 7'd1;
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++)
            chain_r[255 - 32 * i -: 32] <= chain_r[255 - 32 * i -: 32] + v_r[255 - 32 * i -: 32];
          // a block compressed after the marker leaves the length for the next one
          final_blk_r <= final_blk_r | pad80_r;
          rnd_r  <= '0;
          widx_r <= '0;
        end
        ST_EMIT: begin
          if (out_tready) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) begin
              fill_r    <= '0;
              bits_r    <= '0;
              closing_r <= 1'b0;
              for (int i = 0; i < 8; i++) chain_r[255 - 32 * i -: 32] <= init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {5'd0, widx_r, chain_r[255 - 32 * widx_r -: 32]};
  assign out_tlast  = (widx_r == 3'd7);

endmodule

>>> dv/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       present;
    logic       closing;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // Hash round constants and initial chaining value (FIPS 180-4)
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] StartChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_byte_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  msg_word_t    pending_words [$];
  digest_word_t digest_fifo [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned idle_cycles;
  logic        in_taken;

  // Predictor state: chaining value, block buffer, fill level and bit count
  logic [31:0] hash_chain [8];
  logic [7:0]  block_buf [64];
  int unsigned block_fill;
  logic [63:0] bit_total;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_buf();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 16; r++) begin
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
           + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    block_buf[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_buf();
      block_fill = 0;
    end
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_chain[i] = StartChain[i];
    block_fill = 0;
    bit_total = '0;
  endtask

  // Advance the predictor by one accepted word; queue the digest when it closes
  task automatic predict_word(input msg_word_t mw);
    logic [63:0]  len_bits;
    digest_word_t dw;
    if (mw.present) begin
      bit_total += 64'd8;
      absorb_byte(mw.msg_byte);
    end
    if (mw.closing) begin
      len_bits = bit_total;
      absorb_byte(8'h80);
      while (block_fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.digest = hash_chain[i];
        dw.index = i[2:0];
        dw.last = (i == 7);
        digest_fifo.push_back(dw);
      end
      restart_hash();
    end
  endtask

  function automatic msg_word_t mk_word(input logic [7:0] b, input logic p, input logic c);
    msg_word_t mw;
    mw.msg_byte = b;
    mw.present = p;
    mw.closing = c;
    return mw;
  endfunction

  // Queue one message of random bytes; close it on the last byte or with an end-only word,
  // and sprinkle in words that carry neither flag
  task automatic queue_message(input int unsigned len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) pending_words.push_back(mk_word(8'($urandom), 1'b0, 1'b0));
      pending_words.push_back(mk_word(8'($urandom), 1'b1, close_on_byte && (i == len - 1)));
    end
    if (!close_on_byte) pending_words.push_back(mk_word(8'($urandom), 1'b0, 1'b1));
  endtask

  // Fill a phase: mostly short messages, now and then one that crosses a block boundary
  task automatic queue_random_phase(input int unsigned n_words);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < n_words) begin
      case ($urandom_range(9))
        0: len = $urandom_range(119, 50);
        1: len = 55 + $urandom_range(1);
        default: len = $urandom_range(12);
      endcase
      queue_message(len);
      queued += len + 1;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || digest_fifo.size() != 0) @(posedge clk);
  endtask

  // Driver: advance to the next word once the current one is taken or none is held
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_tvalid || in_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          msg_word_t mw;
          mw = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= mw.msg_byte;
          in_tuser <= mw.present;
          in_tlast <= mw.closing;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on every accepted input word, check every accepted output word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) predict_word(mk_word(in_tdata, in_tuser[0], in_tlast));
      if (out_tvalid && out_tready) begin
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, got %h last %b",
                   $time, out_tdata, out_tlast);
          error_count++;
        end else begin
          digest_word_t dw;
          dw = digest_fifo.pop_front();
          if (out_tdata !== {5'b0, dw.index, dw.digest} || out_tlast !== dw.last) begin
            $display("%0t: digest mismatch: expected data %h last %b, got data %h last %b",
                     $time, {5'b0, dw.index, dw.digest}, dw.last, out_tdata, out_tlast);
            error_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    error_count = 0;
    send_idle_pct = 17;
    recv_idle_pct = 84;
    restart_hash();
    for (int i = 0; i < 64; i++) block_buf[i] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, "abc" closed on its last byte, byte extremes and a word with
    // neither flag closed by an end-only word, a one-byte message of all ones, another empty one
    pending_words.push_back(mk_word(8'h00, 1'b0, 1'b1));
    pending_words.push_back(mk_word(8'h61, 1'b1, 1'b0));
    pending_words.push_back(mk_word(8'h62, 1'b1, 1'b0));
    pending_words.push_back(mk_word(8'h63, 1'b1, 1'b1));
    pending_words.push_back(mk_word(8'h00, 1'b1, 1'b0));
    pending_words.push_back(mk_word(8'hff, 1'b1, 1'b0));
    pending_words.push_back(mk_word(8'h5a, 1'b0, 1'b0));
    pending_words.push_back(mk_word(8'ha5, 1'b0, 1'b1));
    pending_words.push_back(mk_word(8'hff, 1'b1, 1'b1));
    pending_words.push_back(mk_word(8'hff, 1'b0, 1'b1));
    wait_drained();

    queue_random_phase(35);
    wait_drained();
    send_idle_pct = 84;
    recv_idle_pct = 17;
    queue_random_phase(30);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(35);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
